// ===== sv/b64enc_pkg.sv =====
// Shared types, constants and the character map for the Base64 stream encoder.
// Used by every module of the block; has no dependencies.
`default_nettype none
package b64enc_pkg;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic REG_URL_MODE    = 1'b0;
  localparam logic REG_LINE_LENGTH = 1'b1;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  localparam logic [7:0] CH_UPPER = 8'h41;
  localparam logic [7:0] CH_LOWER = 8'h61;
  localparam logic [7:0] CH_DIGIT = 8'h30;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_PAD   = 8'h3D;
  localparam logic [7:0] CH_NL    = 8'h0A;

  typedef struct packed {
    logic       pad;
    logic [5:0] idx;
  } sym_t;

  typedef struct packed {
    logic            last;
    logic [1:0]      last_idx;
    sym_t [3:0]      sym;
  } entry_t;

  function automatic logic [7:0] map_char(logic [5:0] idx, logic url);
    logic [7:0] i8;
    logic [7:0] c;
    i8 = {2'b00, idx};
    if (idx < 6'd26) begin
      c = CH_UPPER + i8;
    end else if (idx < 6'd52) begin
      c = CH_LOWER + i8 - 8'd26;
    end else if (idx < 6'd62) begin
      c = CH_DIGIT + i8 - 8'd52;
    end else if (idx == 6'd62) begin
      c = url ? CH_MINUS : CH_PLUS;
    end else begin
      c = url ? CH_UNDER : CH_SLASH;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== sv/base64_stream_encoder_top.sv =====
// Top level of the Base64 stream encoder: configuration registers, front end,
// symbol queue and back end. Uses b64enc_pkg and the b64enc_* modules.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------
//   data in  | data_valid/data_stall | data_byte, last_byte
//   char out | char_valid/char_stall | out_char, last_char
//   config   | cfg_we                | cfg_index, cfg_data
//
// The front end takes one byte per cycle while the two-entry queue has room.
// The back end sends one character or newline per cycle unless char_stall
// holds it or the queue is empty; a byte gives one or two characters plus
// any newline and padding, a full 3-byte group four. Synchronous reset
// clears the group phase, queue, line count and output valid flag.
// char_stall holds the output register; a full queue raises data_stall.
`default_nettype none
module base64_stream_encoder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        data_valid,
  output logic             data_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             char_valid,
  input  wire logic        char_stall,
  output logic [7:0]       out_char,
  output logic             last_char,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic                      url_mode;
  logic [7:0]                line_length;
  logic                      q_full;
  logic                      push;
  logic                      pop;
  logic                      head_valid;
  b64enc_pkg::entry_t        push_entry;
  b64enc_pkg::entry_t        head_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      url_mode    <= 1'b0;
      line_length <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        b64enc_pkg::REG_URL_MODE:    url_mode    <= cfg_data[0];
        b64enc_pkg::REG_LINE_LENGTH: line_length <= cfg_data;
        default: ;
      endcase
    end
  end

  b64enc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  b64enc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  b64enc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .url_mode    (url_mode),
    .line_length (line_length),
    .head_valid  (head_valid),
    .head_entry  (head_entry),
    .pop         (pop),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .out_char    (out_char),
    .last_char   (last_char)
  );

endmodule
`default_nettype wire

// ===== sv/b64enc_front.sv =====
// Front end: takes raw bytes, tracks group phase and leftover bits, and
// builds one queue entry of up to four symbols per byte. Uses b64enc_pkg.
`default_nettype none
module b64enc_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                data_valid,
  output logic                     data_stall,
  input  wire logic [7:0]          data_byte,
  input  wire logic                last_byte,
  input  wire logic                q_full,
  output logic                     push,
  output b64enc_pkg::entry_t       push_entry
);

  logic [1:0] group_phase;
  logic [3:0] leftover_bits;
  logic [1:0] group_phase_next;
  logic [3:0] leftover_bits_next;

  assign data_stall = q_full;
  assign push       = data_valid && !q_full;

  always_comb begin
    push_entry          = '0;
    push_entry.last     = last_byte;
    group_phase_next    = b64enc_pkg::PH_FIRST;
    leftover_bits_next  = '0;
    unique case (group_phase)
      b64enc_pkg::PH_SECOND: begin
        push_entry.sym[0].idx = {leftover_bits[1:0], data_byte[7:4]};
        leftover_bits_next    = data_byte[3:0];
        group_phase_next      = b64enc_pkg::PH_THIRD;
        if (last_byte) begin
          push_entry.sym[1].idx = {data_byte[3:0], 2'b00};
          push_entry.sym[2].pad = 1'b1;
          push_entry.last_idx   = 2'd2;
        end
      end
      b64enc_pkg::PH_THIRD: begin
        push_entry.sym[0].idx = {leftover_bits, data_byte[7:6]};
        push_entry.sym[1].idx = data_byte[5:0];
        push_entry.last_idx   = 2'd1;
      end
      default: begin
        push_entry.sym[0].idx = data_byte[7:2];
        leftover_bits_next    = {2'b00, data_byte[1:0]};
        group_phase_next      = b64enc_pkg::PH_SECOND;
        if (last_byte) begin
          push_entry.sym[1].idx = {data_byte[1:0], 4'b0000};
          push_entry.sym[2].pad = 1'b1;
          push_entry.sym[3].pad = 1'b1;
          push_entry.last_idx   = 2'd3;
        end
      end
    endcase
    if (last_byte) begin
      group_phase_next   = b64enc_pkg::PH_FIRST;
      leftover_bits_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_phase   <= b64enc_pkg::PH_FIRST;
      leftover_bits <= '0;
    end else if (push) begin
      group_phase   <= group_phase_next;
      leftover_bits <= leftover_bits_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/b64enc_queue.sv =====
// Two-entry queue of symbol groups between the front end and the back end.
// Uses b64enc_pkg for the entry type and depth constants.
`default_nettype none
module b64enc_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire b64enc_pkg::entry_t  push_entry,
  output logic                     full,
  input  wire logic                pop,
  output logic                     head_valid,
  output b64enc_pkg::entry_t       head_entry
);

  b64enc_pkg::entry_t                 slots [b64enc_pkg::QDEPTH];
  logic [b64enc_pkg::QPTR_W-1:0]      wr_ptr;
  logic [b64enc_pkg::QPTR_W-1:0]      rd_ptr;
  logic [b64enc_pkg::QCNT_W-1:0]      count;

  assign full       = (count == b64enc_pkg::QCNT_W'(b64enc_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/b64enc_back.sv =====
// Back end: walks the head entry symbols one per cycle when not stalled, inserts
// line breaks, maps symbols to ASCII and drives the output register. Uses b64enc_pkg.
`default_nettype none
module b64enc_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                url_mode,
  input  wire logic [7:0]          line_length,
  input  wire logic                head_valid,
  input  wire b64enc_pkg::entry_t  head_entry,
  output logic                     pop,
  output logic                     char_valid,
  input  wire logic                char_stall,
  output logic [7:0]               out_char,
  output logic                     last_char
);

  logic [1:0]        sym_sel;
  logic [7:0]        line_count;
  logic              load;
  logic              emit;
  logic              need_nl;
  logic              end_of_entry;
  b64enc_pkg::sym_t  cur;
  logic [7:0]        cur_char;

  assign load         = !char_valid || !char_stall;
  assign emit         = load && head_valid;
  assign need_nl      = (line_length != 8'd0) && (line_count >= line_length);
  assign end_of_entry = (sym_sel == head_entry.last_idx);
  assign pop          = emit && !need_nl && end_of_entry;
  assign cur          = head_entry.sym[sym_sel];
  assign cur_char     = cur.pad ? b64enc_pkg::CH_PAD
                                : b64enc_pkg::map_char(cur.idx, url_mode);

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
      sym_sel    <= '0;
      line_count <= '0;
    end else begin
      if (load) begin
        char_valid <= head_valid;
      end
      if (emit) begin
        if (need_nl || (end_of_entry && head_entry.last)) begin
          line_count <= '0;
        end else begin
          line_count <= (line_length != 8'd0) ? line_count + 8'd1 : 8'd0;
        end
        if (!need_nl) begin
          if (end_of_entry) begin
            sym_sel <= '0;
          end else begin
            sym_sel <= sym_sel + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char  <= need_nl ? b64enc_pkg::CH_NL : cur_char;
      last_char <= !need_nl && end_of_entry && head_entry.last;
    end
  end

endmodule
`default_nettype wire
